[hdl/ugcc_pkg.sv]
// Shared types, constants and helpers for the undirected graph cycle checker.
// Used by ugcc_ctrl, ugcc_datapath and undirected_graph_cycle_check_top.
package ugcc_pkg;

	localparam int VTX_SLOTS    = 64;
	localparam int VTX_W        = 7;
	localparam int IDX_W        = $clog2(VTX_SLOTS);
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;

	typedef logic [VTX_W-1:0]        vtx_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [VTX_SLOTS-1:0]    row_t;

	localparam vtx_t MAX_VTX     = vtx_t'(VTX_SLOTS);
	localparam idx_t STACK_TOP   = idx_t'(VTX_SLOTS - 1);
	localparam vtx_t VC_RESET    = vtx_t'(64);

	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_BLACK = 2'd1;
	localparam logic [1:0] COLOR_GRAY  = 2'd2;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_CHECK = 2'd2;

	localparam logic [ADDR_W-3:0] REG_VERTEX_COUNT = '0;

	typedef struct packed {
		vtx_t vtx;
		vtx_t parent;
		vtx_t next;
	} frame_t;

	typedef struct packed {
		logic latch_in;
		logic clr_rows;
		logic row_rd_x;
		logic row_wr_x;
		logic row_rd_y;
		logic row_wr_y;
		logic chk_init;
		logic color_rd_root;
		logic root_start;
		logic root_next;
		logic row_load;
		logic scan_adv;
		logic color_rd_y;
		logic pop_black;
		logic stack_rd;
		logic pop_load;
		logic push;
		logic found_set;
		logic res_load;
	} ugcc_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic n_zero;
		logic root_over;
		logic y_over;
		logic y_skip;
		logic y_parent;
		logic col_white;
		logic col_gray;
		logic stk_full;
		logic sp_zero;
		logic out_free;
	} ugcc_sts_t;

	function automatic idx_t vtx_to_idx(input vtx_t v);
		return idx_t'(v - vtx_t'(1));
	endfunction

endpackage

[hdl/undirected_graph_cycle_check_top.sv]
// Undirected graph cycle checker, top level: register port, sequencer, datapath.
// Add edge: read-modify-write of both rows; an add edge with an out-of-range vertex is ignored.
// Check: scans neighbor slots, probes neighbors, probes roots, fetches rows and pops; the
// result word then waits in its output register. Reset: asynchronous, empties the graph
// through row valid flags at once (no clearing pass) and sets vertex_count to 64.
module undirected_graph_cycle_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [6:0]  first_vertex,
	input  logic [6:0]  second_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_cycle
);
	import ugcc_pkg::*;

	vtx_t      vertex_count_q;
	vtx_t      live_n;
	ugcc_cmd_t cmd;
	ugcc_sts_t sts;
	logic      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_VERTEX_COUNT);
	assign prdata  = reg_sel ? DATA_W'(vertex_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			vertex_count_q <= pwdata[VTX_W-1:0];
		end
	end

	assign live_n = (vertex_count_q > MAX_VTX) ? MAX_VTX : vertex_count_q;

	ugcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	ugcc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.live_n        (live_n),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_cycle     (has_cycle)
	);

endmodule

[hdl/ugcc_ctrl.sv]
// Sequencer for the cycle checker: edge updates and the depth-first walk.
// Depends on ugcc_pkg; drives ugcc_datapath through command/status structs.
module ugcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  ugcc_pkg::ugcc_sts_t sts,
	output ugcc_pkg::ugcc_cmd_t cmd
);
	import ugcc_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ADD_RX   = 4'd1;
	localparam logic [3:0] ST_ADD_WX   = 4'd2;
	localparam logic [3:0] ST_ADD_RY   = 4'd3;
	localparam logic [3:0] ST_ADD_WY   = 4'd4;
	localparam logic [3:0] ST_ROOT_RD  = 4'd5;
	localparam logic [3:0] ST_ROOT_CHK = 4'd6;
	localparam logic [3:0] ST_ROW_WAIT = 4'd7;
	localparam logic [3:0] ST_SCAN     = 4'd8;
	localparam logic [3:0] ST_COL_WAIT = 4'd9;
	localparam logic [3:0] ST_POP_WAIT = 4'd10;
	localparam logic [3:0] ST_RESULT   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_CLEAR: cmd.clr_rows = 1'b1;
						FUNC_ADD: begin
							if (sts.range_ok) begin
								cmd.latch_in = 1'b1;
								state_d      = ST_ADD_RX;
							end
						end
						FUNC_CHECK: begin
							cmd.chk_init = 1'b1;
							state_d      = sts.n_zero ? ST_RESULT : ST_ROOT_RD;
						end
						default: ;
					endcase
				end
			end
			ST_ADD_RX: begin
				cmd.row_rd_x = 1'b1;
				state_d      = ST_ADD_WX;
			end
			ST_ADD_WX: begin
				cmd.row_wr_x = 1'b1;
				state_d      = ST_ADD_RY;
			end
			ST_ADD_RY: begin
				cmd.row_rd_y = 1'b1;
				state_d      = ST_ADD_WY;
			end
			ST_ADD_WY: begin
				cmd.row_wr_y = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_ROOT_RD: begin
				if (sts.root_over) begin
					state_d = ST_RESULT;
				end else begin
					cmd.color_rd_root = 1'b1;
					state_d           = ST_ROOT_CHK;
				end
			end
			ST_ROOT_CHK: begin
				if (sts.col_white) begin
					cmd.root_start = 1'b1;
					state_d        = ST_ROW_WAIT;
				end else begin
					cmd.root_next = 1'b1;
					state_d       = ST_ROOT_RD;
				end
			end
			ST_ROW_WAIT: begin
				cmd.row_load = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (sts.y_over) begin
					cmd.pop_black = 1'b1;
					if (sts.sp_zero) begin
						cmd.root_next = 1'b1;
						state_d       = ST_ROOT_RD;
					end else begin
						cmd.stack_rd = 1'b1;
						state_d      = ST_POP_WAIT;
					end
				end else if (sts.y_skip || sts.y_parent) begin
					cmd.scan_adv = 1'b1;
				end else begin
					cmd.scan_adv   = 1'b1;
					cmd.color_rd_y = 1'b1;
					state_d        = ST_COL_WAIT;
				end
			end
			ST_COL_WAIT: begin
				priority if (sts.col_gray) begin
					cmd.found_set = 1'b1;
					state_d       = ST_RESULT;
				end else if (sts.col_white && !sts.stk_full) begin
					cmd.push = 1'b1;
					state_d  = ST_ROW_WAIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_POP_WAIT: begin
				cmd.pop_load = 1'b1;
				state_d      = ST_ROW_WAIT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/ugcc_datapath.sv]
// Adjacency, color and stack memories plus the walk registers and result word.
// Depends on ugcc_pkg; commanded by ugcc_ctrl.
module ugcc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ugcc_pkg::vtx_t      live_n,
	input  ugcc_pkg::vtx_t      first_vertex,
	input  ugcc_pkg::vtx_t      second_vertex,
	input  ugcc_pkg::ugcc_cmd_t cmd,
	output ugcc_pkg::ugcc_sts_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                has_cycle
);
	import ugcc_pkg::*;

	row_t       row_mem [VTX_SLOTS];
	logic [1:0] col_mem [VTX_SLOTS];
	frame_t     stk_mem [VTX_SLOTS];

	row_t   row_vld_q;
	row_t   col_vld_q;
	row_t   row_rdata_q;
	logic   row_rvld_q;
	logic [1:0] col_rdata_q;
	logic   col_rvld_q;
	frame_t stk_rdata_q;

	vtx_t   x_q, y_q, root_q, hit_q;
	vtx_t   cur_v_q, cur_par_q, cur_nxt_q;
	idx_t   sp_q;
	row_t   row_q;
	logic   found_q;
	logic   out_valid_q, has_cycle_q;

	logic   row_re, row_we;
	idx_t   row_raddr, row_waddr;
	row_t   row_wdata, row_eff;
	logic   col_re, col_we;
	idx_t   col_raddr, col_waddr;
	logic [1:0] col_wdata, col_eff;

	assign row_eff = row_rvld_q ? row_rdata_q : '0;
	assign col_eff = col_rvld_q ? col_rdata_q : COLOR_WHITE;

	always_comb begin
		row_re    = 1'b0;
		row_raddr = '0;
		priority if (cmd.row_rd_x) begin
			row_re    = 1'b1;
			row_raddr = vtx_to_idx(x_q);
		end else if (cmd.row_rd_y) begin
			row_re    = 1'b1;
			row_raddr = vtx_to_idx(y_q);
		end else if (cmd.root_start) begin
			row_re    = 1'b1;
			row_raddr = vtx_to_idx(root_q);
		end else if (cmd.push) begin
			row_re    = 1'b1;
			row_raddr = vtx_to_idx(hit_q);
		end else if (cmd.pop_load) begin
			row_re    = 1'b1;
			row_raddr = vtx_to_idx(stk_rdata_q.vtx);
		end else begin
			row_re = 1'b0;
		end
	end

	assign row_we    = cmd.row_wr_x | cmd.row_wr_y;
	assign row_waddr = cmd.row_wr_x ? vtx_to_idx(x_q) : vtx_to_idx(y_q);
	assign row_wdata = row_eff
		| (row_t'(1) << (cmd.row_wr_x ? vtx_to_idx(y_q) : vtx_to_idx(x_q)));

	always_comb begin
		col_we    = 1'b0;
		col_waddr = '0;
		col_wdata = COLOR_WHITE;
		priority if (cmd.root_start) begin
			col_we    = 1'b1;
			col_waddr = vtx_to_idx(root_q);
			col_wdata = COLOR_GRAY;
		end else if (cmd.push) begin
			col_we    = 1'b1;
			col_waddr = vtx_to_idx(hit_q);
			col_wdata = COLOR_GRAY;
		end else if (cmd.pop_black) begin
			col_we    = 1'b1;
			col_waddr = vtx_to_idx(cur_v_q);
			col_wdata = COLOR_BLACK;
		end else begin
			col_we = 1'b0;
		end
	end

	assign col_re    = cmd.color_rd_root | cmd.color_rd_y;
	assign col_raddr = cmd.color_rd_root ? vtx_to_idx(root_q) : vtx_to_idx(cur_nxt_q);

	// memories
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rdata_q <= row_mem[row_raddr];
		end
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		if (col_re) begin
			col_rdata_q <= col_mem[col_raddr];
		end
		if (cmd.push) begin
			stk_mem[sp_q] <= '{vtx: cur_v_q, parent: cur_par_q, next: cur_nxt_q};
		end
		if (cmd.stack_rd) begin
			stk_rdata_q <= stk_mem[sp_q - idx_t'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q   <= '0;
			col_vld_q   <= '0;
			row_rvld_q  <= 1'b0;
			col_rvld_q  <= 1'b0;
			root_q      <= vtx_t'(1);
			sp_q        <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_rows) begin
				row_vld_q <= '0;
			end else if (row_we) begin
				row_vld_q[row_waddr] <= 1'b1;
			end
			if (cmd.chk_init) begin
				col_vld_q <= '0;
			end else if (col_we) begin
				col_vld_q[col_waddr] <= 1'b1;
			end
			if (row_re) begin
				row_rvld_q <= row_vld_q[row_raddr];
			end
			if (col_re) begin
				col_rvld_q <= col_vld_q[col_raddr];
			end
			if (cmd.chk_init) begin
				root_q <= vtx_t'(1);
			end else if (cmd.root_next) begin
				root_q <= root_q + vtx_t'(1);
			end
			if (cmd.root_start) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q <= sp_q + idx_t'(1);
			end else if (cmd.stack_rd) begin
				sp_q <= sp_q - idx_t'(1);
			end
			if (cmd.chk_init) begin
				found_q <= 1'b0;
			end else if (cmd.found_set) begin
				found_q <= 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			x_q <= first_vertex;
			y_q <= second_vertex;
		end
		if (cmd.row_load) begin
			row_q <= row_eff;
		end
		if (cmd.color_rd_y) begin
			hit_q <= cur_nxt_q;
		end
		if (cmd.res_load) begin
			has_cycle_q <= found_q;
		end
		priority if (cmd.root_start) begin
			cur_v_q   <= root_q;
			cur_par_q <= '0;
			cur_nxt_q <= vtx_t'(1);
		end else if (cmd.push) begin
			cur_v_q   <= hit_q;
			cur_par_q <= cur_v_q;
			cur_nxt_q <= vtx_t'(1);
		end else if (cmd.pop_load) begin
			cur_v_q   <= stk_rdata_q.vtx;
			cur_par_q <= stk_rdata_q.parent;
			cur_nxt_q <= stk_rdata_q.next;
		end else if (cmd.scan_adv) begin
			cur_nxt_q <= cur_nxt_q + vtx_t'(1);
		end else begin
			cur_nxt_q <= cur_nxt_q;
		end
	end

	assign sts.range_ok  = (first_vertex != '0) && (first_vertex <= live_n)
		&& (second_vertex != '0) && (second_vertex <= live_n);
	assign sts.n_zero    = (live_n == '0);
	assign sts.root_over = (root_q > live_n);
	assign sts.y_over    = (cur_nxt_q > live_n);
	assign sts.y_skip    = (cur_nxt_q == cur_v_q) || !row_q[vtx_to_idx(cur_nxt_q)];
	assign sts.y_parent  = (cur_nxt_q == cur_par_q);
	assign sts.col_white = (col_eff == COLOR_WHITE);
	assign sts.col_gray  = (col_eff == COLOR_GRAY);
	assign sts.stk_full  = (sp_q == STACK_TOP);
	assign sts.sp_zero   = (sp_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign has_cycle = has_cycle_q;

endmodule
